// ===== rtl/core/move_to_front_codec_top_macros.svh =====
// Assertion macros shared by the move-to-front codec RTL.
`ifndef MOVE_TO_FRONT_CODEC_TOP_MACROS_SVH
`define MOVE_TO_FRONT_CODEC_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MTF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("move_to_front_codec: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define MTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("move_to_front_codec: next-cycle check failed");

`endif

// ===== rtl/core/mtf_pkg.sv =====
// Types and constants for the move-to-front codec.
`default_nettype none

package mtf_pkg;

    // Width of one symbol table entry (letter offset).
    localparam int SYM_W = 5;
    // Character code of the first letter.
    localparam logic [7:0] LETTER_BASE = 8'h61;

    // Mode register codes.
    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    // Input request payload.
    typedef struct packed {
        logic [7:0] item_value;
        logic       restart;
    } t_in_item;

    // Result payload.
    typedef struct packed {
        logic [7:0] result_value;
        logic       bad_index;
    } t_out_item;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        t_mode            mode;
        logic             load;
        logic             act;
        logic             restart;
        logic [SYM_W-1:0] key;
        logic [7:0]       pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/mtf_cell.sv =====
// One symbol table cell: holds one entry, matches it, and shifts from its neighbor.
`default_nettype none

module mtf_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mtf_pkg::t_cell_ctl           i_ctl,
    input  wire  [mtf_pkg::SYM_W-1:0]    i_prev_sym,
    input  wire                          i_tail_hit,
    output logic [mtf_pkg::SYM_W-1:0]    o_sym,
    output logic                         o_hit,
    output logic                         o_tail_hit
);

    localparam logic [mtf_pkg::SYM_W-1:0] RESET_SYM = mtf_pkg::SYM_W'(CELL_IDX);
    localparam logic [7:0]                CELL_POS  = 8'(CELL_IDX);

    logic [mtf_pkg::SYM_W-1:0] r_sym;
    logic [mtf_pkg::SYM_W-1:0] n_sym;
    logic [mtf_pkg::SYM_W-1:0] eff_sym;

    // Apply a pending restart before matching
    assign eff_sym = i_ctl.restart ? RESET_SYM : r_sym;
    assign o_sym   = eff_sym;

    // Match on the letter in encode mode, on the position in decode mode
    always_comb begin
        if (i_ctl.mode == mtf_pkg::MODE_ENCODE) begin
            o_hit = (eff_sym == i_ctl.key);
        end else begin
            o_hit = (i_ctl.pos == CELL_POS);
        end
    end

    // Pass the hit toward the front: every cell up to the hit shifts
    assign o_tail_hit = o_hit | i_tail_hit;

    // Shift from the neighbor when this cell lies at or before the hit
    assign n_sym = (i_ctl.act && o_tail_hit) ? i_prev_sym : eff_sym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= RESET_SYM;
        end else if (i_ctl.load) begin
            r_sym <= n_sym;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/move_to_front_codec_top.sv =====
// Top level of the move-to-front codec: request channel, cell row and result register.
// Usage:
//   Input requests arrive on i_in_valid / o_in_ready with an item value and a
//   restart flag; results leave on o_out_valid / i_out_ready. A request with
//   restart set puts the table back to a, b, c, ... before it is handled.
//   Mode is written through i_cfg_we / i_cfg_wdata while the block is idle:
//   0 encodes letters to positions, 1 decodes positions to letters.
//   Encode of a byte that is not a table letter gives no result; decode of a
//   position past the table gives a result with bad_index set and value 0.
// Timing:
//   One request is taken per cycle while o_in_ready is high. Its result appears
//   in the output register in the cycle after acceptance. Each request is
//   finished in a single pass through the row of ALPHABET_SIZE cells: every
//   cell compares its entry in parallel, the hit ripples toward the front, and
//   every cell at or before the hit shifts from its neighbor at the same clock edge.
// Reset and stall:
//   Reset (synchronous, active low) sets mode to encode, the table to a..z and
//   empties the output register. While a result waits, o_in_ready follows
//   i_out_ready: a new request is taken in the cycle the waiting result leaves;
//   otherwise o_in_ready stays low and the table holds.
`default_nettype none

module move_to_front_codec_top #(
    parameter int ALPHABET_SIZE = 26
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_wdata,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  mtf_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output mtf_pkg::t_out_item o_out_data
);

    `include "move_to_front_codec_top_macros.svh"

    localparam int SW = mtf_pkg::SYM_W;

    mtf_pkg::t_mode     r_mode;
    mtf_pkg::t_cell_ctl ctl;
    logic               in_accept;
    logic [7:0]         letter_off;
    logic               letter_ok;
    logic               pos_ok;
    logic               has_result;

    logic [SW-1:0]      cell_sym  [ALPHABET_SIZE];
    logic [SW-1:0]      prev_sym  [ALPHABET_SIZE];
    logic               cell_hit  [ALPHABET_SIZE];
    logic               tail_hit  [ALPHABET_SIZE+1];
    logic [ALPHABET_SIZE-1:0] hit_vec;

    logic [SW-1:0]      held_sym;
    logic [SW-1:0]      hit_pos;

    logic               r_out_valid;
    logic               n_out_valid;
    mtf_pkg::t_out_item r_out_data;
    mtf_pkg::t_out_item n_out_data;

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mtf_pkg::MODE_ENCODE;
        end else if (i_cfg_we) begin
            r_mode <= mtf_pkg::t_mode'(i_cfg_wdata);
        end
    end

    // Accept a request whenever the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Decode the request
    assign letter_off = i_in_data.item_value - mtf_pkg::LETTER_BASE;
    assign letter_ok  = (i_in_data.item_value >= mtf_pkg::LETTER_BASE)
                     && (letter_off < 8'(ALPHABET_SIZE));
    assign pos_ok     = (i_in_data.item_value < 8'(ALPHABET_SIZE));

    always_comb begin
        ctl.mode    = r_mode;
        ctl.load    = in_accept;
        ctl.restart = i_in_data.restart;
        ctl.key     = letter_off[SW-1:0];
        ctl.pos     = i_in_data.item_value;
        if (r_mode == mtf_pkg::MODE_ENCODE) begin
            ctl.act = letter_ok;
        end else begin
            ctl.act = pos_ok;
        end
    end

    // Build the row of cells; the entry at the hit enters at the front
    assign tail_hit[ALPHABET_SIZE] = 1'b0;

    for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
        if (k == 0) begin : g_front
            assign prev_sym[k] = held_sym;
        end else begin : g_rest
            assign prev_sym[k] = cell_sym[k-1];
        end

        mtf_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_prev_sym (prev_sym[k]),
            .i_tail_hit (tail_hit[k+1]),
            .o_sym      (cell_sym[k]),
            .o_hit      (cell_hit[k]),
            .o_tail_hit (tail_hit[k])
        );

        assign hit_vec[k] = cell_hit[k];
    end

    // Collect the hit entry and its position
    always_comb begin
        held_sym = '0;
        hit_pos  = '0;
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
            if (cell_hit[k]) begin
                held_sym = held_sym | cell_sym[k];
                hit_pos  = hit_pos | SW'(k);
            end
        end
    end

    // Form the result
    always_comb begin
        has_result = 1'b0;
        n_out_data = '0;
        if (r_mode == mtf_pkg::MODE_ENCODE) begin
            has_result              = letter_ok;
            n_out_data.result_value = 8'(hit_pos);
        end else begin
            has_result = 1'b1;
            if (pos_ok) begin
                n_out_data.result_value = mtf_pkg::LETTER_BASE + 8'(held_sym);
            end else begin
                n_out_data.bad_index = 1'b1;
            end
        end
    end

    // Load, hold or drop the result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = has_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && has_result) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The table stays a permutation: a valid letter or position hits exactly one cell
    `MTF_ASSERT_SAME(a_one_hit, ctl.act, $onehot(hit_vec))
    // A bad position never carries a letter
    `MTF_ASSERT_SAME(a_bad_zero, r_out_valid && r_out_data.bad_index,
        r_out_data.result_value == 8'h00)
    // An encoded position stays inside the table
    `MTF_ASSERT_NEXT(a_enc_range,
        in_accept && r_mode == mtf_pkg::MODE_ENCODE && letter_ok,
        r_out_valid && !r_out_data.bad_index
            && r_out_data.result_value < 8'(ALPHABET_SIZE))

endmodule

`default_nettype wire
